// ----- rtl/fcba_pkg.sv -----
// Package with the shared types and constants of the chained block allocator.
package fcba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 128;
  localparam int unsigned BLOCK_BYTES_DEF = 1024;
  localparam int unsigned MAX_OUT         = 64;
  localparam int unsigned SIZE_W          = 16;
  localparam int unsigned IDX_W           = 7;
  localparam int unsigned LINK_W          = 8;
  localparam int unsigned NEED_W          = 7;
  localparam int unsigned REM_W           = 17;

  localparam logic [LINK_W-1:0] LINK_END  = 8'd254;
  localparam logic [LINK_W-1:0] LINK_FREE = 8'd255;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_READ  = 1'b1
  } fcba_cmd_e;

  typedef enum logic [1:0] {
    STATUS_ALLOC = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_READ  = 2'd3
  } fcba_status_e;

  typedef struct packed {
    fcba_cmd_e          command;
    logic [SIZE_W-1:0]  size_bytes;
    logic [IDX_W-1:0]   entry_index;
  } fcba_in_t;

  typedef struct packed {
    fcba_status_e       status;
    logic [IDX_W-1:0]   block_index;
    logic [LINK_W-1:0]  next_entry;
    logic               last;
  } fcba_out_t;

  typedef struct packed {
    logic               done;
    logic [NEED_W-1:0]  blocks;
  } fcba_cnt_t;

endpackage

// ----- rtl/fcba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fcba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fcba_blk_cnt.sv -----
// Iterative subtractor that rounds a byte size up to a count of whole blocks, stopping at MAX_OUT + 1.
module fcba_blk_cnt #(
  parameter int unsigned BLOCK_BYTES = fcba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [fcba_pkg::SIZE_W-1:0]      size_i,
  output fcba_pkg::fcba_cnt_t              cnt_o
);

  import fcba_pkg::*;

  localparam logic [REM_W-1:0]  BlockBytes = REM_W'(BLOCK_BYTES);
  localparam logic [NEED_W-1:0] CountStop  = NEED_W'(MAX_OUT + 1);

  logic              busy_q, busy_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [NEED_W-1:0] cnt_q, cnt_d;
  logic              finish;

  assign finish = busy_q && ((rem_q == '0) || (cnt_q == CountStop));

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = {1'b0, size_i};
      cnt_d  = '0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      rem_d = (rem_q > BlockBytes) ? (rem_q - BlockBytes) : '0;
      cnt_d = cnt_q + NEED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign cnt_o.done   = finish;
  assign cnt_o.blocks = cnt_q;

endmodule

// ----- rtl/fat_chain_block_allocator.sv -----
// Top level of the chained block allocator with its sequencer and link table.
// An allocate transfer first runs the size through a subtract loop, one block per cycle,
// then takes blocks one at a time: a scan pointer walks the used bits one entry per cycle
// from the lowest free entry, and each block takes the scan step that finds it, a link step
// that writes it into the previous block's entry (none for the first block) and an emit step
// that hands the result to the output register once it is free. The scan pointer never moves
// back, so it passes at most NUM_BLOCKS entries in total. A read transfer takes its link from
// the registered read of the link table RAM. The input is stalled while an item is in work;
// the next item is taken as soon as the last result sits in the output register.
module fat_chain_block_allocator #(
  parameter int unsigned NUM_BLOCKS  = fcba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = fcba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcba_pkg::fcba_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcba_pkg::fcba_out_t out_data_o
);

  import fcba_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SIZE,
    ST_SCAN,
    ST_LINK,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [NUM_BLOCKS-1:0] used_q;
  logic [CW-1:0]       ptr_q;
  logic [AW-1:0]       cur_q;
  logic [AW-1:0]       prev_q;
  logic                have_prev_q;
  logic [NEED_W-1:0]   need_q;
  logic [NEED_W-1:0]   done_cnt_q;
  logic [IDX_W-1:0]    idx_q;
  fcba_out_t           res_q;
  fcba_out_t           out_data_q;
  logic                out_valid_q;

  fcba_cnt_t           cnt;
  logic                in_xfer;
  logic                out_free;
  logic                out_load;
  logic                ptr_end;
  logic                ptr_used;
  logic                idx_hit;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [LINK_W-1:0]   ram_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = ((state_q == ST_RD) || (state_q == ST_EMIT)) && out_free;
  assign ptr_end     = (ptr_q == CW'(NUM_BLOCKS));
  assign ptr_used    = used_q[ptr_q[AW-1:0]];
  assign idx_hit     = (32'(idx_q) < NUM_BLOCKS) && used_q[AW'(idx_q)];

  assign ram_we    = ((state_q == ST_SCAN) && !ptr_end && !ptr_used) || (state_q == ST_LINK);
  assign ram_waddr = (state_q == ST_LINK) ? prev_q : ptr_q[AW-1:0];
  assign ram_wdata = (state_q == ST_LINK) ? LINK_W'(cur_q) : LINK_END;
  assign ram_re    = in_xfer && (in_data_i.command == CMD_READ);

  fcba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(in_data_i.entry_index)),
    .rdata_o (ram_rdata)
  );

  fcba_blk_cnt #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_blk_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer && (in_data_i.command == CMD_ALLOC)),
    .size_i  (in_data_i.size_bytes),
    .cnt_o   (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      ptr_q       <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_q <= in_data_i.entry_index;
            if (in_data_i.command == CMD_READ) begin
              state_q <= ST_RD;
            end else begin
              state_q <= ST_SIZE;
            end
          end
        end
        ST_RD: begin
          if (out_free) begin
            out_data_q.status      <= STATUS_READ;
            out_data_q.block_index <= idx_q;
            out_data_q.next_entry  <= idx_hit ? ram_rdata : LINK_FREE;
            out_data_q.last        <= 1'b1;
            state_q                <= ST_IDLE;
          end
        end
        ST_SIZE: begin
          if (cnt.done) begin
            need_q      <= cnt.blocks;
            done_cnt_q  <= '0;
            have_prev_q <= 1'b0;
            res_q.block_index <= '0;
            res_q.next_entry  <= '0;
            res_q.last        <= 1'b1;
            if (cnt.blocks == '0) begin
              res_q.status <= STATUS_EMPTY;
              state_q      <= ST_EMIT;
            end else if (cnt.blocks > NEED_W'(MAX_OUT)) begin
              res_q.status <= STATUS_FULL;
              state_q      <= ST_EMIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ptr_end) begin
            res_q.status      <= STATUS_FULL;
            res_q.block_index <= '0;
            res_q.next_entry  <= '0;
            res_q.last        <= 1'b1;
            state_q           <= ST_EMIT;
          end else if (ptr_used) begin
            ptr_q <= ptr_q + CW'(1);
          end else begin
            used_q[ptr_q[AW-1:0]] <= 1'b1;
            ptr_q                 <= ptr_q + CW'(1);
            cur_q                 <= ptr_q[AW-1:0];
            done_cnt_q            <= done_cnt_q + NEED_W'(1);
            res_q.status          <= STATUS_ALLOC;
            res_q.block_index     <= IDX_W'(ptr_q[AW-1:0]);
            res_q.next_entry      <= '0;
            res_q.last            <= ((done_cnt_q + NEED_W'(1)) == need_q);
            if (have_prev_q) begin
              state_q <= ST_LINK;
            end else begin
              prev_q      <= ptr_q[AW-1:0];
              have_prev_q <= 1'b1;
              state_q     <= ST_EMIT;
            end
          end
        end
        ST_LINK: begin
          prev_q  <= cur_q;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_q  <= res_q;
            state_q     <= res_q.last ? ST_IDLE : ST_SCAN;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(used_q) & ~used_q) == '0)
    else $error("A table entry was released.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt.done |-> (state_q == ST_SIZE))
    else $error("Block count finished outside of sizing.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q <= CW'(NUM_BLOCKS)))
    else $error("Scan pointer ran past the table.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> have_prev_q && used_q[prev_q] && used_q[cur_q])
    else $error("Link written between entries that are not allocated.");

endmodule
